FILE: hdl/crs_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crs_pkg
// Types and fixed constants shared by the chroma range stretch modules.
// -----------------------------------------------------------------------------
package crs_pkg;

   localparam int CHROMA_W    = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_MEASURE = 2'd1,
      OP_APPLY   = 2'd2
   } op_type;

   // One apply pixel with the statistics that were current when it arrived.
   typedef struct packed {
      logic [CHROMA_W-1:0] lightness;
      logic [CHROMA_W-1:0] chroma;
      logic [CHROMA_W-1:0] hue;
      logic [CHROMA_W-1:0] alpha;
      logic [CHROMA_W-1:0] min_chroma;
      logic [CHROMA_W-1:0] max_chroma;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_SAT,
      BK_HOLD
   } back_state_type;

endpackage

FILE: hdl/crs_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crs_front
// Accepts pixels, keeps the chroma minimum and maximum, and forwards apply
// pixels with a snapshot of the statistics into the queue.
// -----------------------------------------------------------------------------
module crs_front
   import crs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_opcode,
   input  logic [CHROMA_W-1:0] req_in_lightness,
   input  logic [CHROMA_W-1:0] req_in_chroma,
   input  logic [CHROMA_W-1:0] req_in_hue,
   input  logic [CHROMA_W-1:0] req_in_alpha,
   input  logic                q_full,
   output logic                q_push,
   output item_type            q_item
);

   logic [CHROMA_W-1:0] min_ff, min_in;
   logic [CHROMA_W-1:0] max_ff, max_in;
   logic                accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      q_push = 1'b0;
      if (accept) begin
         case (op_type'(req_opcode))
            OP_CLEAR: begin
               min_in = {CHROMA_W{1'b1}};
               max_in = '0;
            end
            OP_MEASURE: begin
               if (req_in_chroma < min_ff) min_in = req_in_chroma;
               if (req_in_chroma > max_ff) max_in = req_in_chroma;
            end
            OP_APPLY: begin
               q_push = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      q_item.lightness  = req_in_lightness;
      q_item.chroma     = req_in_chroma;
      q_item.hue        = req_in_hue;
      q_item.alpha      = req_in_alpha;
      q_item.min_chroma = min_ff;
      q_item.max_chroma = max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= {CHROMA_W{1'b1}};
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule

FILE: hdl/crs_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crs_queue
// Short register queue between the front and the back.
// -----------------------------------------------------------------------------
module crs_queue
   import crs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: hdl/crs_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crs_back
// Stretches one queued pixel at a time: a multiply by full scale, a restoring
// division by the measured span, then saturation; an empty range skips both.
// -----------------------------------------------------------------------------
module crs_back
   import crs_pkg::*;
#(
   parameter int FRAC_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  item_type            q_item,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [CHROMA_W-1:0] rsp_out_lightness,
   output logic [CHROMA_W-1:0] rsp_out_chroma,
   output logic [CHROMA_W-1:0] rsp_out_hue,
   output logic [CHROMA_W-1:0] rsp_out_alpha
);

   localparam int FULL_SCALE = 100 << FRAC_BITS;
   localparam int SCALE_W    = 7 + FRAC_BITS;
   localparam int PROD_W     = CHROMA_W + SCALE_W;
   localparam int CNT_W      = $clog2(PROD_W);
   localparam int TOP_VALUE  = (FULL_SCALE > 65535) ? 65535 : FULL_SCALE;
   localparam logic [PROD_W-1:0] TOP = PROD_W'(TOP_VALUE);

   back_state_type        state_ff, state_in;
   logic [CHROMA_W-1:0]   light_ff, light_in;
   logic [CHROMA_W-1:0]   chroma_ff, chroma_in;
   logic [CHROMA_W-1:0]   hue_ff, hue_in;
   logic [CHROMA_W-1:0]   alpha_ff, alpha_in;
   logic [CHROMA_W-1:0]   span_ff, span_in;
   logic [CHROMA_W-1:0]   num_ff, num_in;
   logic                  flat_ff, flat_in;
   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [CHROMA_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CHROMA_W:0]     trial;
   logic [CHROMA_W:0]     diff;

   // One quotient bit per cycle; the dividend shifts out of the top of quo.
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, span_ff};

   always_comb begin
      state_in  = state_ff;
      light_in  = light_ff;
      chroma_in = chroma_ff;
      hue_in    = hue_ff;
      alpha_in  = alpha_ff;
      span_in   = span_ff;
      num_in    = num_ff;
      flat_in   = flat_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      q_pop     = 1'b0;
      rsp_empty = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               light_in  = q_item.lightness;
               chroma_in = q_item.chroma;
               hue_in    = q_item.hue;
               alpha_in  = q_item.alpha;
               span_in   = q_item.max_chroma - q_item.min_chroma;
               flat_in   = (q_item.max_chroma <= q_item.min_chroma);
               num_in    = (q_item.chroma > q_item.min_chroma) ?
                           q_item.chroma - q_item.min_chroma : '0;
               state_in  = BK_MUL;
            end
         end
         BK_MUL: begin
            quo_in = PROD_W'(num_ff) * PROD_W'(FULL_SCALE);
            rem_in = '0;
            cnt_in = CNT_W'(PROD_W - 1);
            // An empty range passes the pixel through untouched.
            state_in = flat_ff ? BK_HOLD : BK_DIV;
         end
         BK_DIV: begin
            if (!diff[CHROMA_W]) begin
               rem_in = diff[CHROMA_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CHROMA_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = BK_SAT;
         end
         BK_SAT: begin
            chroma_in = (quo_ff > TOP) ? TOP[CHROMA_W-1:0] : quo_ff[CHROMA_W-1:0];
            state_in  = BK_HOLD;
         end
         BK_HOLD: begin
            rsp_empty = 1'b0;
            if (rsp_pop) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      light_ff  <= light_in;
      chroma_ff <= chroma_in;
      hue_ff    <= hue_in;
      alpha_ff  <= alpha_in;
      span_ff   <= span_in;
      num_ff    <= num_in;
      flat_ff   <= flat_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
   end

   assign rsp_out_lightness = light_ff;
   assign rsp_out_chroma    = chroma_ff;
   assign rsp_out_hue       = hue_ff;
   assign rsp_out_alpha     = alpha_ff;

endmodule

FILE: hdl/chroma_range_stretch.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// chroma_range_stretch
// Clear and measure transfers give no result. An apply pixel's result is held
// in the back end after the multiply, the restoring division and saturation;
// an empty range skips the division and saturation and passes it through.
// The back end works on one apply pixel at a time and takes the next from the
// queue only once the current result has been popped.
// Synchronous reset sets the minimum to all ones, the maximum to zero and
// empties the queue and the result register.
// -----------------------------------------------------------------------------
module chroma_range_stretch
   import crs_pkg::*;
#(
   parameter int CHROMA_FRAC_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_opcode,
   input  logic [CHROMA_W-1:0] req_in_lightness,
   input  logic [CHROMA_W-1:0] req_in_chroma,
   input  logic [CHROMA_W-1:0] req_in_hue,
   input  logic [CHROMA_W-1:0] req_in_alpha,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [CHROMA_W-1:0] rsp_out_lightness,
   output logic [CHROMA_W-1:0] rsp_out_chroma,
   output logic [CHROMA_W-1:0] rsp_out_hue,
   output logic [CHROMA_W-1:0] rsp_out_alpha
);

   logic     q_push, q_full, q_pop, q_empty;
   item_type q_push_item, q_pop_item;

   crs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_in_lightness (req_in_lightness),
      .req_in_chroma    (req_in_chroma),
      .req_in_hue       (req_in_hue),
      .req_in_alpha     (req_in_alpha),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_push_item)
   );

   crs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_pop_item)
   );

   crs_back #(
      .FRAC_BITS (CHROMA_FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_item            (q_pop_item),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_lightness (rsp_out_lightness),
      .rsp_out_chroma    (rsp_out_chroma),
      .rsp_out_hue       (rsp_out_hue),
      .rsp_out_alpha     (rsp_out_alpha)
   );

endmodule
